/* rtl/mck_pkg.sv */
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, constants and the character code lookup for the Morse keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int DOT_W   = 10;
    localparam int DUR_W   = 12;
    localparam int CNT_W   = 3;
    localparam int SYM_W   = 5;

    // register reset value
    localparam logic [DOT_W-1:0] DOT_RESET = 10'd100;

    // symbol count field of a table entry and the longest character
    localparam logic [7:0]       COUNT_MASK  = 8'h07;
    localparam logic [CNT_W-1:0] MAX_SYMBOLS = 3'd5;

    // ascii range bounds
    localparam logic [CHAR_W-1:0] ASC_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASC_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASC_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASC_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] ASC_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASC_NINE    = 8'h39;

    // interval length in dot units
    typedef logic [1:0] t_units;
    localparam t_units UNITS_1 = 2'd0;
    localparam t_units UNITS_3 = 2'd1;
    localparam t_units UNITS_4 = 2'd2;

    // packed code tables: symbols msb first (1 dot, 0 dash), count in low bits
    localparam logic [7:0] LETTER_CODES [26] = '{
        8'h82, 8'h74, 8'h54, 8'h63, 8'h81, 8'hD4, 8'h23, 8'hF4,
        8'hC2, 8'h84, 8'h43, 8'hB4, 8'h02, 8'h42, 8'h03, 8'h94,
        8'h24, 8'hA3, 8'hE3, 8'h01, 8'hC3, 8'hE4, 8'h83, 8'h64,
        8'h44, 8'h34
    };

    localparam logic [7:0] DIGIT_CODES [10] = '{
        8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5, 8'hFD, 8'h7D, 8'h3D,
        8'h1D, 8'h0D
    };

    // payload of one transfer on each channel
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              end_of_message;
    } t_in_item;

    typedef struct packed {
        logic             lamp_lit;
        logic [DUR_W-1:0] duration_ms;
        logic             last;
    } t_out_item;

    // result of the table lookup
    typedef struct packed {
        logic             known;
        logic [SYM_W-1:0] symbols;
        logic [CNT_W-1:0] count;
    } t_lookup;

    // controller to datapath
    typedef struct packed {
        logic   load;
        logic   emit;
        logic   shift;
        logic   lit;
        logic   last;
        t_units units;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_known;
        logic in_has_sym;
        logic is_dot;
        logic last_sym;
        logic eom;
        logic out_free;
    } t_sts;

    // look up one ascii byte; anything but a letter or digit is unknown
    function automatic t_lookup mck_lookup(input logic [CHAR_W-1:0] ch);
        t_lookup          res;
        logic [7:0]       code;
        logic [CHAR_W-1:0] off_u;
        logic [CHAR_W-1:0] off_l;
        logic [CHAR_W-1:0] off_d;
        logic [CNT_W-1:0] cnt;
        off_u = ch - ASC_UPPER_A;
        off_l = ch - ASC_LOWER_A;
        off_d = ch - ASC_ZERO;
        code  = 8'h00;
        res.known = 1'b1;
        if (ch >= ASC_UPPER_A && ch <= ASC_UPPER_Z) begin
            code = LETTER_CODES[off_u[4:0]];
        end else if (ch >= ASC_LOWER_A && ch <= ASC_LOWER_Z) begin
            code = LETTER_CODES[off_l[4:0]];
        end else if (ch >= ASC_ZERO && ch <= ASC_NINE) begin
            code = DIGIT_CODES[off_d[3:0]];
        end else begin
            res.known = 1'b0;
        end
        cnt = CNT_W'(code & COUNT_MASK);
        res.count   = (cnt > MAX_SYMBOLS) ? MAX_SYMBOLS : cnt;
        res.symbols = code[7:8-SYM_W];
        return res;
    endfunction

endpackage

/* rtl/mck_ctrl.sv */
// ----------------------------------------------------------------------------
// mck_ctrl
// Sequencer that walks one character through its lamp intervals.
// ----------------------------------------------------------------------------
module mck_ctrl
    import mck_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SYM_ON   = 3'd1;
    localparam logic [2:0] ST_SYM_OFF  = 3'd2;
    localparam logic [2:0] ST_CHAR_GAP = 3'd3;
    localparam logic [2:0] ST_MSG_GAP  = 3'd4;
    localparam logic [2:0] ST_WORD_GAP = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // only take a character when the previous one is fully keyed
    assign o_in_stall = (r_state != ST_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.units = UNITS_1;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.in_known) begin
                        n_state = ST_WORD_GAP;
                    end else if (i_sts.in_has_sym) begin
                        n_state = ST_SYM_ON;
                    end else begin
                        n_state = ST_CHAR_GAP;
                    end
                end
            end
            ST_SYM_ON: begin
                o_cmd.lit   = 1'b1;
                o_cmd.units = i_sts.is_dot ? UNITS_1 : UNITS_3;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_SYM_OFF;
                end
            end
            ST_SYM_OFF: begin
                o_cmd.units = UNITS_1;
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.shift = 1'b1;
                    n_state     = i_sts.last_sym ? ST_CHAR_GAP : ST_SYM_ON;
                end
            end
            ST_CHAR_GAP: begin
                o_cmd.units = UNITS_3;
                o_cmd.last  = !i_sts.eom;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.eom ? ST_MSG_GAP : ST_IDLE;
                end
            end
            ST_MSG_GAP: begin
                o_cmd.units = UNITS_4;
                o_cmd.last  = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_WORD_GAP: begin
                o_cmd.units = UNITS_4;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_CHAR_GAP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/mck_dpath.sv */
// ----------------------------------------------------------------------------
// mck_dpath
// Dot length register, symbol shifter, duration scaling and output register.
// ----------------------------------------------------------------------------
module mck_dpath
    import mck_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [DOT_W-1:0] i_cfg_data,
    input  t_in_item         i_in_data,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    logic [DOT_W-1:0] r_dot;
    logic [SYM_W-1:0] r_sym;
    logic [CNT_W-1:0] r_count;
    logic             r_eom;
    logic             r_out_valid;
    t_out_item        r_out;
    t_lookup          lkp;
    logic [DUR_W-1:0] dur;

    // character table lookup on the incoming byte
    assign lkp = mck_lookup(i_in_data.character);

    // status towards the controller
    assign o_sts.in_known   = lkp.known;
    assign o_sts.in_has_sym = (lkp.count != '0);
    assign o_sts.is_dot     = r_sym[SYM_W-1];
    assign o_sts.last_sym   = (r_count == CNT_W'(1));
    assign o_sts.eom        = r_eom;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    // duration scaling: one, three or four dot lengths
    always_comb begin
        case (i_cmd.units)
            UNITS_1: dur = {2'b00, r_dot};
            UNITS_3: dur = {2'b00, r_dot} + {1'b0, r_dot, 1'b0};
            UNITS_4: dur = {r_dot, 2'b00};
            default: dur = '0;
        endcase
    end

    // dot length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= DOT_RESET;
        end else if (i_cfg_valid) begin
            r_dot <= i_cfg_data;
        end
    end

    // symbol shifter and character context
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym   <= lkp.symbols;
            r_count <= lkp.count;
            r_eom   <= i_in_data.end_of_message;
        end else if (i_cmd.shift) begin
            r_sym   <= {r_sym[SYM_W-2:0], 1'b0};
            r_count <= r_count - CNT_W'(1);
        end
    end

    // output register, held while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.lamp_lit    <= i_cmd.lit;
            r_out.duration_ms <= dur;
            r_out.last        <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/morse_character_keyer.sv */
// ----------------------------------------------------------------------------
// morse_character_keyer
// Keys one ascii character per transfer into Morse lamp on/off intervals.
// ----------------------------------------------------------------------------
// Each accepted character produces its intervals one per output transfer:
// for a letter or digit, on for one (dot) or three (dash) dot lengths and
// off for one per symbol, then off for three; any other byte gives off for
// four then off for three; end of message adds a final off for four. The
// last flag marks the final interval of each character. The block keys one
// character at a time: it takes the character, then the sequencer emits
// one interval per cycle into the single output register while the output
// is not stalled. The dot length register may be written at any cycle and
// is meant to change only while no character is in progress.
module morse_character_keyer
    import mck_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [DOT_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    mck_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    mck_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // a taken character blocks the input until it is keyed
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not blocked after character transfer");

    // the final interval frees the input on the next cycle
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.last) |=> !o_in_stall)
        else $error("input still blocked after final interval");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

    // every lit interval is followed by a dark one
    a_lit_then_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.lit) |=> !cmd.lit)
        else $error("lit interval not followed by a gap");

endmodule

/* bench/morse_character_keyer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morse_character_keyer_tb
// Self-checking bench for the Morse character keyer. Characters are pushed
// through the input channel under varying idle and stall patterns. A
// scoreboard keys each accepted character independently and compares every
// output interval, field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------
module morse_character_keyer_tb
    import mck_pkg::*;
();

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 8;
    localparam int SETTLE_LEN  = 20;
    localparam int HOLD_LEN    = 300;
    localparam int PHASE_ITEMS = 55;
    localparam int CYCLE_LIMIT = 200000;

    // unit counts of the intervals
    localparam int DOT_UNITS  = 1;
    localparam int DASH_UNITS = 3;
    localparam int CHAR_GAP   = 3;
    localparam int WORD_GAP   = 4;

    // symbol patterns, 'A' and '0' in the top byte
    localparam logic [26*8-1:0] LETTER_PATTERNS = {
        8'h82, 8'h74, 8'h54, 8'h63, 8'h81, 8'hD4, 8'h23, 8'hF4,
        8'hC2, 8'h84, 8'h43, 8'hB4, 8'h02, 8'h42, 8'h03, 8'h94,
        8'h24, 8'hA3, 8'hE3, 8'h01, 8'hC3, 8'hE4, 8'h83, 8'h64,
        8'h44, 8'h34
    };
    localparam logic [10*8-1:0] DIGIT_PATTERNS = {
        8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5, 8'hFD, 8'h7D, 8'h3D,
        8'h1D, 8'h0D
    };

    // predicts the intervals of each character and checks them in order
    class keyer_scoreboard;
        t_out_item        pending_intervals[$];
        logic [DOT_W-1:0] dot_len;
        int unsigned      errors;

        function new();
            dot_len = DOT_RESET;
            errors  = 0;
        endfunction

        function void set_dot_length(logic [DOT_W-1:0] value);
            dot_len = value;
        endfunction

        function int outstanding();
            return pending_intervals.size();
        endfunction

        function void add_interval(logic lit, int units);
            t_out_item iv;
            iv.lamp_lit    = lit;
            iv.duration_ms = DUR_W'(DUR_W'(dot_len) * DUR_W'(units));
            iv.last        = 1'b0;
            pending_intervals.push_back(iv);
        endfunction

        // key one accepted character into its expected intervals
        function void key_character(t_in_item item);
            logic [7:0] pattern;
            logic       known;
            int         n_sym;
            int         k;
            known   = 1'b1;
            pattern = 8'h00;
            if (item.character >= "A" && item.character <= "Z") begin
                pattern = LETTER_PATTERNS[(25 - (item.character - "A")) * 8 +: 8];
            end else if (item.character >= "a" && item.character <= "z") begin
                pattern = LETTER_PATTERNS[(25 - (item.character - "a")) * 8 +: 8];
            end else if (item.character >= "0" && item.character <= "9") begin
                pattern = DIGIT_PATTERNS[(9 - (item.character - "0")) * 8 +: 8];
            end else begin
                known = 1'b0;
            end
            if (!known) begin
                add_interval(1'b0, WORD_GAP);
            end else begin
                n_sym = pattern[2:0];
                if (n_sym > 5) n_sym = 5;
                for (k = 0; k < n_sym; k++) begin
                    add_interval(1'b1, pattern[7] ? DOT_UNITS : DASH_UNITS);
                    add_interval(1'b0, DOT_UNITS);
                    pattern = pattern << 1;
                end
            end
            add_interval(1'b0, CHAR_GAP);
            if (item.end_of_message) add_interval(1'b0, WORD_GAP);
            pending_intervals[pending_intervals.size() - 1].last = 1'b1;
        endfunction

        // compare one output transfer with the oldest prediction
        function void check_interval(t_out_item got);
            t_out_item want;
            if (pending_intervals.size() == 0) begin
                $error("interval with none expected: lit %0d dur %0d last %0d",
                       got.lamp_lit, got.duration_ms, got.last);
                errors++;
                return;
            end
            want = pending_intervals.pop_front();
            if (got.lamp_lit !== want.lamp_lit) begin
                $error("lamp_lit: expected %0d, got %0d", want.lamp_lit, got.lamp_lit);
                errors++;
            end
            if (got.duration_ms !== want.duration_ms) begin
                $error("duration_ms: expected %0d, got %0d",
                       want.duration_ms, got.duration_ms);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [DOT_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out_data;

    keyer_scoreboard  sb;
    int               send_idle_pct;
    int               stall_pct;
    bit               hold_off;
    int unsigned      cycles;

    morse_character_keyer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // watch both channels for transfers
    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (i_in_valid && !o_in_stall) sb.key_character(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_interval(o_out_data);
        end
    end

    // receiver: random stall, or a long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_off = 1'b0;
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offer one character and wait for its transfer
    task automatic offer_character(input logic [CHAR_W-1:0] ch, input logic eom);
        t_in_item item;
        item.character      = ch;
        item.end_of_message = eom;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // mostly letters and digits, some arbitrary bytes
    task automatic send_random_char();
        logic [CHAR_W-1:0] ch;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 60)
            ch = 8'h41 + CHAR_W'($urandom_range(25)) | ($urandom_range(1) ? 8'h20 : 8'h00);
        else if (pick < 80)
            ch = 8'h30 + CHAR_W'($urandom_range(9));
        else
            ch = CHAR_W'($urandom_range(255));
        offer_character(ch, $urandom_range(99) < 15);
    endtask

    // let every expected interval out, then allow the sequencer to settle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_LEN) @(posedge i_clk);
    endtask

    task automatic write_dot_length(input logic [DOT_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_dot_length(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic [DOT_W-1:0] dot_values [8];
        int               ph;
        int               n;
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off      = 1'b0;
        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: table ends, range boundaries, high bytes, end of message
        offer_character("A", 1'b0);
        offer_character("Z", 1'b0);
        offer_character("a", 1'b0);
        offer_character("z", 1'b0);
        offer_character("0", 1'b0);
        offer_character("9", 1'b0);
        offer_character("U", 1'b0);
        offer_character("u", 1'b1);
        offer_character(8'h00, 1'b0);
        offer_character(8'hFF, 1'b0);
        offer_character(8'h80, 1'b1);
        offer_character(8'h40, 1'b0);
        offer_character(8'h5B, 1'b0);
        offer_character(8'h60, 1'b0);
        offer_character(8'h7B, 1'b0);
        offer_character(8'h2F, 1'b0);
        offer_character(8'h3A, 1'b0);
        offer_character(" ", 1'b0);
        offer_character("5", 1'b1);
        offer_character("E", 1'b0);
        offer_character("T", 1'b1);
        offer_character(8'h7F, 1'b1);

        // random phases, each setting a dot length and an idle and stall pattern
        dot_values = '{10'd1023, 10'd1, 10'd0, DOT_W'($urandom_range(1023)),
                       10'd1023, DOT_W'($urandom_range(1023)),
                       DOT_W'($urandom_range(1023)), 10'd100};
        for (ph = 0; ph < 8; ph++) begin
            write_dot_length(dot_values[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            // back-pressure: receiver holds off while characters keep coming
            if (ph == 4) hold_off = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) send_random_char();
        end

        drain();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
rtl/mck_pkg.sv
rtl/mck_ctrl.sv
rtl/mck_dpath.sv
rtl/morse_character_keyer.sv
bench/morse_character_keyer_tb.sv
